[rtl/ntm_pkg.sv]
package ntm_pkg;

  localparam int TIME_W    = 63;
  localparam int THR_W     = 32;
  localparam int IDX_OUT_W = 12;
  localparam int CNT_OUT_W = 13;
  localparam int APB_AW    = 3;
  localparam logic [THR_W-1:0] THR_RESET = 32'd50000000;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_MATCH   = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_STORED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_ORDER   = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  // datapath operations
  typedef enum logic [3:0] {
    U_IDLE,
    U_STORE,
    U_CLEAR,
    U_QINIT,
    U_MID,
    U_CMP,
    U_RDB,
    U_RDA,
    U_DB,
    U_DA,
    U_PICK,
    U_THR,
    U_EMIT
  } uop_t;

  // sequencer jump conditions
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_EMPTY,
    J_DONE,
    J_OUTFREE
  } jmp_t;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_STORE = 4'd1;
  localparam step_t S_CLEAR = 4'd2;
  localparam step_t S_QINIT = 4'd3;
  localparam step_t S_QMID  = 4'd4;
  localparam step_t S_QCMP  = 4'd5;
  localparam step_t S_QRDB  = 4'd6;
  localparam step_t S_QRDA  = 4'd7;
  localparam step_t S_QDB   = 4'd8;
  localparam step_t S_QDA   = 4'd9;
  localparam step_t S_QPICK = 4'd10;
  localparam step_t S_QTHR  = 4'd11;
  localparam step_t S_EMIT  = 4'd12;

  typedef struct packed {
    uop_t  uop;
    jmp_t  jmp;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      S_IDLE:  w = '{uop: U_IDLE,  jmp: J_DISPATCH, target: S_IDLE};
      S_STORE: w = '{uop: U_STORE, jmp: J_GOTO,     target: S_EMIT};
      S_CLEAR: w = '{uop: U_CLEAR, jmp: J_GOTO,     target: S_EMIT};
      S_QINIT: w = '{uop: U_QINIT, jmp: J_EMPTY,    target: S_EMIT};
      S_QMID:  w = '{uop: U_MID,   jmp: J_DONE,     target: S_QRDB};
      S_QCMP:  w = '{uop: U_CMP,   jmp: J_GOTO,     target: S_QMID};
      S_QRDB:  w = '{uop: U_RDB,   jmp: J_NEXT,     target: S_IDLE};
      S_QRDA:  w = '{uop: U_RDA,   jmp: J_NEXT,     target: S_IDLE};
      S_QDB:   w = '{uop: U_DB,    jmp: J_NEXT,     target: S_IDLE};
      S_QDA:   w = '{uop: U_DA,    jmp: J_NEXT,     target: S_IDLE};
      S_QPICK: w = '{uop: U_PICK,  jmp: J_NEXT,     target: S_IDLE};
      S_QTHR:  w = '{uop: U_THR,   jmp: J_GOTO,     target: S_EMIT};
      S_EMIT:  w = '{uop: U_EMIT,  jmp: J_OUTFREE,  target: S_IDLE};
      default: w = '{uop: U_IDLE,  jmp: J_GOTO,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/ntm_ram.sv]
module ntm_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/nearest_timestamp_matcher.sv]
// Store, clear, empty-table query: op step, then emit; next item is taken back in idle.
// Other queries: init, k lower-bound search iterations, neighbour reads, distances, pick, threshold,
//   emit (k at most floor(log2(entries)) + 1). Emit registers the result once the output is free.
// Each search iteration is one registered read of the timestamp RAM and one compare.
// rst_n is synchronous: table emptied, threshold back to 50 ms, no result pending.
// RAM contents are not cleared; only entries below the count are ever used.
module nearest_timestamp_matcher
  import ntm_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_op,
  input  logic [TIME_W-1:0]     in_time_ns,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [IDX_OUT_W-1:0]  out_match_index,
  output logic [TIME_W-1:0]     out_distance_ns,
  output logic [CNT_OUT_W-1:0]  out_entries_held,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ucode_t            uw;
  step_t             step_r, step_nxt;
  logic [CW-1:0]     cnt_r, lo_r, hi_r;
  logic [AW-1:0]     mid_r, idx_b_r, res_idx_r;
  logic              has_a_r;
  logic [TIME_W-1:0] t_r, last_r, tb_r, ta_r, db_r, da_r, res_dist_r;
  status_t           res_status_r;
  logic [THR_W-1:0]  thr_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [TIME_W-1:0]    out_dist_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic [CW-1:0]     span, mid_full, cnt_m1;
  logic [AW-1:0]     mid, idx_b, raddr;
  logic [TIME_W-1:0] rdata;
  logic              use_last, store_full, store_order, store_ok, out_free;
  logic [31:0]       idx_ext, cnt_ext;

  function automatic logic [TIME_W-1:0] abs_diff(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign uw = ucode_rom(step_r);

  assign span     = hi_r - lo_r;
  assign mid_full = lo_r + (span >> 1);
  assign mid      = mid_full[AW-1:0];
  assign cnt_m1   = cnt_r - CW'(1);
  assign use_last = (lo_r == cnt_r);
  assign idx_b    = use_last ? cnt_m1[AW-1:0] : lo_r[AW-1:0];

  assign store_full  = (cnt_r == CW'(TABLE_DEPTH));
  assign store_order = (cnt_r != '0) && (t_r < last_r);
  assign store_ok    = (uw.uop == U_STORE) && !store_full && !store_order;
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    case (uw.uop)
      U_RDB:   raddr = idx_b;
      U_RDA:   raddr = idx_b_r - AW'(1);
      default: raddr = mid;
    endcase
  end

  ntm_ram #(
    .WIDTH(TIME_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (store_ok),
    .waddr(cnt_r[AW-1:0]),
    .wdata(t_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  // sequencer
  always_comb begin
    step_nxt = step_r + step_t'(1);
    unique case (uw.jmp)
      J_NEXT: step_nxt = step_r + step_t'(1);
      J_GOTO: step_nxt = uw.target;
      J_DISPATCH: begin
        step_nxt = S_IDLE;
        if (in_valid) begin
          case (in_op)
            OP_STORE: step_nxt = S_STORE;
            OP_QUERY: step_nxt = S_QINIT;
            OP_CLEAR: step_nxt = S_CLEAR;
            default:  step_nxt = S_IDLE;
          endcase
        end
      end
      J_EMPTY:   step_nxt = (cnt_r == '0) ? uw.target : step_r + step_t'(1);
      J_DONE:    step_nxt = (lo_r >= hi_r) ? uw.target : step_r + step_t'(1);
      J_OUTFREE: step_nxt = out_free ? uw.target : step_r;
      default:   step_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (uw.uop == U_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_IDLE;
      cnt_r       <= '0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (psel && penable && pwrite && !paddr[2]) begin
        thr_r <= pwdata;
      end
      if ((uw.uop == U_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (uw.uop)
        U_STORE: if (store_ok) begin
          cnt_r <= cnt_r + CW'(1);
        end
        U_CLEAR: cnt_r <= '0;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (uw.uop)
      U_IDLE: t_r <= in_time_ns;
      U_STORE: begin
        res_dist_r <= '0;
        if (store_full) begin
          res_status_r <= ST_FULL;
          res_idx_r    <= '0;
        end else if (store_order) begin
          res_status_r <= ST_ORDER;
          res_idx_r    <= '0;
        end else begin
          res_status_r <= ST_STORED;
          res_idx_r    <= cnt_r[AW-1:0];
          last_r       <= t_r;
        end
      end
      U_CLEAR: begin
        res_status_r <= ST_CLEARED;
        res_idx_r    <= '0;
        res_dist_r   <= '0;
      end
      U_QINIT: begin
        res_status_r <= ST_NOMATCH;
        res_idx_r    <= '0;
        res_dist_r   <= '0;
        lo_r         <= '0;
        hi_r         <= cnt_r;
      end
      U_MID: mid_r <= mid;
      U_CMP: begin
        if (rdata < t_r) begin
          lo_r <= CW'(mid_r) + CW'(1);
        end else begin
          hi_r <= CW'(mid_r);
        end
      end
      U_RDB: begin
        idx_b_r <= idx_b;
        has_a_r <= !use_last && (lo_r != '0);
      end
      U_RDA: tb_r <= rdata;
      U_DB: begin
        ta_r <= rdata;
        db_r <= abs_diff(tb_r, t_r);
      end
      U_DA: da_r <= abs_diff(ta_r, t_r);
      U_PICK: begin
        if (has_a_r && (da_r < db_r)) begin
          res_idx_r  <= idx_b_r - AW'(1);
          res_dist_r <= da_r;
        end else begin
          res_idx_r  <= idx_b_r;
          res_dist_r <= db_r;
        end
      end
      U_THR: res_status_r <= (res_dist_r <= TIME_W'(thr_r)) ? ST_MATCH : ST_NOMATCH;
      U_EMIT: if (out_free) begin
        out_status_r <= res_status_r;
        out_idx_r    <= idx_ext[IDX_OUT_W-1:0];
        out_dist_r   <= res_dist_r;
        out_cnt_r    <= cnt_ext[CNT_OUT_W-1:0];
      end
      default: ;
    endcase
  end

  assign idx_ext = 32'(res_idx_r);
  assign cnt_ext = 32'(cnt_r);

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_match_index  = out_idx_r;
  assign out_distance_ns  = out_dist_r;
  assign out_entries_held = out_cnt_r;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : thr_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.uop == U_CMP) |-> (CW'(mid_r) >= lo_r && CW'(mid_r) < hi_r))
    else $error("search probe outside window");

  a_hi_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.uop == U_MID) |-> (hi_r <= cnt_r && lo_r <= hi_r))
    else $error("search window outside table");

  a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
    store_ok |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("store did not advance count");
`endif

endmodule
